@@ rtl/slfr_pkg.sv @@
`default_nettype none

package slfr_pkg;

    localparam int unsigned BUFFER_BYTES = 124;

    // position runs 0..BUFFER_BYTES
    localparam int unsigned POS_W = $clog2(BUFFER_BYTES + 1);
    // wide enough for position + 1 and length + 3
    localparam int unsigned CMP_W = 10;

    localparam logic [7:0]  SYNC_BYTE   = 8'h7E;
    localparam logic [7:0]  SECOND_BYTE = 8'h55;
    localparam logic [15:0] CRC_POLY    = 16'h8408;
    localparam logic [15:0] CRC_INIT    = 16'hFFFF;
    localparam logic [POS_W-1:0] CMD_POS = POS_W'(8);

    // CRC-16/X-25, reflected, one byte per call
    function automatic logic [15:0] crc_byte(input logic [15:0] crc, input logic [7:0] b);
        logic [15:0] c;
        c = crc ^ {8'h00, b};
        for (int k = 0; k < 8; k++) begin
            if (c[0])
            begin
                c = (c >> 1) ^ CRC_POLY;
            end
            else
            begin
                c = c >> 1;
            end
        end
        return c;
    endfunction

endpackage

`default_nettype wire

@@ rtl/sync_length_frame_receiver_crc16.sv @@
// Channel  | Dir | Signals                        | Content
// s        | in  | s_tvalid s_tready s_tdata[7:0] | rx_byte
// m        | out | m_tvalid m_tready m_tuser[0]   | crc_ok
//          |     | m_tdata[15:0]                  | frame_length, command_code
//
// One beat per cycle unless a result waits on a stalled m: a byte is held in the input register, then
// the frame tracker and the byte-wide CRC update its state in a single pass.
// A completed frame's result is registered for m when its last byte leaves the input register.
// Reset clears the position and the header state and loads the CRC with 0xFFFF.
// With m stalled and a result waiting, s takes at most one more byte and then holds.
`default_nettype none

module sync_length_frame_receiver_crc16 (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [7:0]  s_tdata,   // [7:0] rx_byte
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [15:0]      m_tdata,   // [7:0] frame_length, [15:8] command_code
    output logic [0:0]       m_tuser    // [0] crc_ok
);

    localparam int unsigned PW = slfr_pkg::POS_W;
    localparam int unsigned CW = slfr_pkg::CMP_W;

    logic          in_valid_reg;
    logic [7:0]    in_byte_reg;

    logic [PW-1:0] pos_reg,     pos_next;
    logic [7:0]    sh_reg,      sh_next;
    logic [7:0]    len_reg,     len_next;
    logic [15:0]   crc_reg,     crc_next;
    logic [7:0]    crc_lo_reg,  crc_lo_next;
    logic [7:0]    cmd_reg,     cmd_next;

    logic          out_valid_reg;
    logic          out_ok_reg,  out_ok_next;
    logic [7:0]    out_len_reg;
    logic [7:0]    out_cmd_reg;

    logic          done;
    logic          adv;
    logic [PW-1:0] p;
    logic [CW-1:0] p_w;
    logic [CW-1:0] len_w;
    logic [15:0]   rx_crc;

    always_comb
    begin
        p           = (pos_reg >= PW'(slfr_pkg::BUFFER_BYTES)) ? '0 : pos_reg;
        pos_next    = pos_reg;
        sh_next     = sh_reg;
        len_next    = len_reg;
        crc_next    = crc_reg;
        crc_lo_next = crc_lo_reg;
        cmd_next    = cmd_reg;
        done        = 1'b0;
        p_w         = CW'(p);
        len_w       = '0;
        rx_crc      = '0;
        out_ok_next = 1'b0;

        if (p == '0)
        begin
            pos_next = '0;
            if (in_byte_reg == slfr_pkg::SYNC_BYTE)
            begin
                crc_next = slfr_pkg::CRC_INIT;
                cmd_next = '0;
                pos_next = PW'(1);
            end
        end
        else
        begin
            if (p == PW'(1))
            begin
                sh_next = in_byte_reg;
            end
            if (p == PW'(2))
            begin
                len_next = in_byte_reg;
            end
            len_w = CW'(len_next);
            if (p_w >= CW'(2) && p_w <= len_w)
            begin
                crc_next = slfr_pkg::crc_byte(crc_reg, in_byte_reg);
            end
            if (p_w == len_w + CW'(1))
            begin
                crc_lo_next = in_byte_reg;
            end
            if (p == slfr_pkg::CMD_POS)
            begin
                cmd_next = in_byte_reg;
            end
            pos_next = p + PW'(1);

            // frame ends once position passes L+2
            if (sh_next == slfr_pkg::SECOND_BYTE && p_w + CW'(1) >= len_w + CW'(3))
            begin
                done        = 1'b1;
                rx_crc      = {in_byte_reg, crc_lo_next};
                out_ok_next = (len_next >= 8'd2) && (~crc_next == rx_crc);
                pos_next    = '0;
            end
        end
    end

    assign adv      = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || adv;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            pos_reg       <= '0;
            sh_reg        <= '0;
            len_reg       <= '0;
            crc_reg       <= slfr_pkg::CRC_INIT;
            crc_lo_reg    <= '0;
            cmd_reg       <= '0;
        end
        else
        begin
            if (s_tvalid && s_tready)
            begin
                in_valid_reg <= 1'b1;
            end
            else if (adv)
            begin
                in_valid_reg <= 1'b0;
            end

            if (adv)
            begin
                pos_reg    <= pos_next;
                sh_reg     <= sh_next;
                len_reg    <= len_next;
                crc_reg    <= crc_next;
                crc_lo_reg <= crc_lo_next;
                cmd_reg    <= cmd_next;
            end

            if (adv && done)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (m_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // payload, no reset
    always_ff @(posedge clk)
    begin
        if (s_tvalid && s_tready)
        begin
            in_byte_reg <= s_tdata;
        end
        if (adv && done)
        begin
            out_ok_reg  <= out_ok_next;
            out_len_reg <= len_next;
            out_cmd_reg <= cmd_next;
        end
    end

    assign m_tvalid   = out_valid_reg;
    assign m_tdata    = {out_cmd_reg, out_len_reg};
    assign m_tuser[0] = out_ok_reg;

    a_pos_range: assert property (@(posedge clk) disable iff (!rst_n)
        pos_reg <= PW'(slfr_pkg::BUFFER_BYTES))
        else $error("frame position beyond buffer size");

    a_done_rewind: assert property (@(posedge clk) disable iff (!rst_n)
        adv && done |=> pos_reg == '0 && out_valid_reg)
        else $error("completed frame did not rewind position or post result");

    a_ok_len: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && out_ok_reg |-> out_len_reg >= 8'd2)
        else $error("crc_ok flagged on a frame shorter than two bytes");

    a_stall_full: assert property (@(posedge clk) disable iff (!rst_n)
        !s_tready |-> in_valid_reg && out_valid_reg)
        else $error("input stalled while a stage is free");

endmodule

`default_nettype wire

@@ tb/sv/frame_report_checker.sv @@
module frame_report_checker (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    input  logic        s_tready,
    input  logic [7:0]  s_tdata,    // [7:0] rx_byte
    input  logic        m_tvalid,
    input  logic        m_tready,
    input  logic [15:0] m_tdata,    // [7:0] frame_length, [15:8] command_code
    input  logic [0:0]  m_tuser,    // [0] crc_ok
    output int          fail_count,
    output int          pending,
    output int          reports_seen,
    output int          good_crc_seen
);

    typedef struct packed {
        logic       crc_ok;
        logic [7:0] frame_length;
        logic [7:0] command_code;
    } frame_report_t;

    frame_report_t reports_due[$];
    frame_report_t want;

    int unsigned frame_pos;
    logic [7:0]  hdr_byte;
    logic [7:0]  len_byte;
    logic [7:0]  crc_lo_byte;
    logic [7:0]  cmd_byte;
    logic [15:0] crc_acc;

    // bit-serial form of the reflected X-25 update, LSB first
    function automatic logic [15:0] x25_feed(input logic [15:0] crc, input logic [7:0] b);
        logic [15:0] c;
        c = crc;
        for (int i = 0; i < 8; i++)
        begin
            c = (c[0] ^ b[i]) ? ((c >> 1) ^ slfr_pkg::CRC_POLY) : (c >> 1);
        end
        return c;
    endfunction

    function automatic void take_byte(input logic [7:0] b);
        int unsigned   p;
        int unsigned   len;
        frame_report_t r;
        if (frame_pos >= slfr_pkg::BUFFER_BYTES)
        begin
            frame_pos = 0;
        end
        p = frame_pos;
        if (p == 0)
        begin
            // drop anything but the sync byte
            if (b == slfr_pkg::SYNC_BYTE)
            begin
                crc_acc   = slfr_pkg::CRC_INIT;
                cmd_byte  = 8'h00;
                frame_pos = 1;
            end
        end
        else
        begin
            if (p == 1)
            begin
                hdr_byte = b;
            end
            if (p == 2)
            begin
                len_byte = b;
            end
            // position 1 still compares against the previous length
            len = len_byte;
            if (p >= 2 && p <= len)
            begin
                crc_acc = x25_feed(crc_acc, b);
            end
            if (p == len + 1)
            begin
                crc_lo_byte = b;
            end
            if (p == slfr_pkg::CMD_POS)
            begin
                cmd_byte = b;
            end
            frame_pos = p + 1;
            if (hdr_byte == slfr_pkg::SECOND_BYTE && frame_pos >= len + 3)
            begin
                r.crc_ok       = (len >= 2) && (~crc_acc == {b, crc_lo_byte});
                r.frame_length = len_byte;
                r.command_code = cmd_byte;
                reports_due.push_back(r);
                frame_pos = 0;
            end
        end
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            frame_pos     = 0;
            hdr_byte      = 8'h00;
            len_byte      = 8'h00;
            crc_lo_byte   = 8'h00;
            cmd_byte      = 8'h00;
            crc_acc       = slfr_pkg::CRC_INIT;
            reports_due.delete();
            pending       = 0;
            fail_count    = 0;
            reports_seen  = 0;
            good_crc_seen = 0;
        end
        else
        begin
            if (s_tvalid && s_tready)
            begin
                take_byte(s_tdata);
            end
            if (m_tvalid && m_tready)
            begin
                if (reports_due.size() == 0)
                begin
                    $error("unexpected report beat: crc_ok %0d frame_length %0d command_code %0d",
                           m_tuser[0], m_tdata[7:0], m_tdata[15:8]);
                    fail_count++;
                end
                else
                begin
                    want = reports_due.pop_front();
                    reports_seen++;
                    if (m_tuser[0] === 1'b1)
                    begin
                        good_crc_seen++;
                    end
                    if (m_tuser[0] !== want.crc_ok)
                    begin
                        $error("crc_ok: expected %0d, got %0d", want.crc_ok, m_tuser[0]);
                        fail_count++;
                    end
                    if (m_tdata[7:0] !== want.frame_length)
                    begin
                        $error("frame_length: expected %0d, got %0d",
                               want.frame_length, m_tdata[7:0]);
                        fail_count++;
                    end
                    if (m_tdata[15:8] !== want.command_code)
                    begin
                        $error("command_code: expected 0x%02h, got 0x%02h",
                               want.command_code, m_tdata[15:8]);
                        fail_count++;
                    end
                end
            end
            pending = reports_due.size();
        end
    end

endmodule

@@ tb/sv/sync_length_frame_receiver_crc16_tb.sv @@
module sync_length_frame_receiver_crc16_tb;

    localparam int LIMIT       = 300000;
    localparam int PHASE_BEATS = 300;

    logic        clk      = 1'b0;
    logic        rst_n    = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [7:0]  s_tdata  = 8'h00;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [15:0] m_tdata;
    logic [0:0]  m_tuser;

    int idle_pct;
    int stall_pct;
    int beats_sent;
    int ignored_beats;
    int fail_count;
    int pending;
    int reports_seen;
    int good_crc_seen;

    sync_length_frame_receiver_crc16 dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    frame_report_checker chk (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_tvalid      (s_tvalid),
        .s_tready      (s_tready),
        .s_tdata       (s_tdata),
        .m_tvalid      (m_tvalid),
        .m_tready      (m_tready),
        .m_tdata       (m_tdata),
        .m_tuser       (m_tuser),
        .fail_count    (fail_count),
        .pending       (pending),
        .reports_seen  (reports_seen),
        .good_crc_seen (good_crc_seen)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        m_tready <= ($urandom_range(99) >= stall_pct);
    end

    function automatic logic [15:0] x25_fold(input logic [15:0] crc, input logic [7:0] b);
        logic [15:0] c;
        c = crc ^ {8'h00, b};
        repeat (8)
        begin
            c = c[0] ? ((c >> 1) ^ 16'h8408) : (c >> 1);
        end
        return c;
    endfunction

    task automatic put_byte(input logic [7:0] b);
        bit taken;
        while ($urandom_range(99) < idle_pct)
        begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= b;
        taken = 1'b0;
        // look at tready mid-cycle; the beat moves on the following edge
        while (!taken)
        begin
            @(negedge clk);
            taken = s_tready;
            @(posedge clk);
        end
        beats_sent++;
    endtask

    task automatic send_noise();
        logic [7:0] b;
        repeat ($urandom_range(1, 3))
        begin
            b = 8'($urandom);
            if (b == slfr_pkg::SYNC_BYTE)
            begin
                b = ~b;
            end
            put_byte(b);
            ignored_beats++;
        end
    endtask

    task automatic send_frame(input logic [7:0] hdr, input logic [7:0] len, input bit corrupt);
        logic [15:0] crc;
        logic [7:0]  d;
        put_byte(slfr_pkg::SYNC_BYTE);
        put_byte(hdr);
        put_byte(len);
        if (hdr != slfr_pkg::SECOND_BYTE || len > slfr_pkg::BUFFER_BYTES - 3)
        begin
            // fill up to the wrap so the next sync lands on position 0
            repeat (slfr_pkg::BUFFER_BYTES - 3)
            begin
                put_byte(8'($urandom));
            end
        end
        else if (len == 8'd1)
        begin
            put_byte(8'($urandom));
        end
        else if (len >= 8'd2)
        begin
            crc = x25_fold(slfr_pkg::CRC_INIT, len);
            for (int k = 3; k <= len; k++)
            begin
                d = 8'($urandom);
                crc = x25_fold(crc, d);
                put_byte(d);
            end
            crc = ~crc;
            if (corrupt)
            begin
                crc = crc ^ (16'h0001 << $urandom_range(15));
            end
            put_byte(crc[7:0]);
            put_byte(crc[15:8]);
        end
    endtask

    task automatic drain();
        s_tvalid <= 1'b0;
        repeat (3) @(negedge clk);
        while (pending != 0)
        begin
            @(negedge clk);
        end
        repeat (4) @(posedge clk);
    endtask

    initial
    begin
        repeat (LIMIT) @(posedge clk);
        $display("CHECKS FAILED");
        $finish;
    end

    initial
    begin
        int         kind;
        int         start;
        logic [7:0] hdr;
        idle_pct  = 0;
        stall_pct = 0;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // wrong start bytes, zero and one length, shortest frame, CRC high at position 8
        put_byte(8'h00);
        put_byte(8'hFF);
        ignored_beats += 2;
        send_frame(slfr_pkg::SECOND_BYTE, 8'd0, 1'b0);
        send_frame(slfr_pkg::SECOND_BYTE, 8'd1, 1'b0);
        send_frame(slfr_pkg::SECOND_BYTE, 8'd2, 1'b0);
        send_frame(slfr_pkg::SECOND_BYTE, 8'd6, 1'b0);
        drain();

        for (int ph = 0; ph < 4; ph++)
        begin
            case (ph)
                0: begin idle_pct = 0;  stall_pct = 0;  end
                1: begin idle_pct = 64; stall_pct = 0;  end
                2: begin idle_pct = 0;  stall_pct = 64; end
                default: begin idle_pct = 26; stall_pct = 26; end
            endcase
            start = beats_sent - ignored_beats;
            while (beats_sent - ignored_beats - start < PHASE_BEATS)
            begin
                if ($urandom_range(9) == 0)
                begin
                    send_noise();
                end
                kind = $urandom_range(99);
                if (kind < 2)
                begin
                    hdr = 8'($urandom);
                    if (hdr == slfr_pkg::SECOND_BYTE)
                    begin
                        hdr = 8'h00;
                    end
                    send_frame(hdr, 8'($urandom), 1'b0);
                end
                else if (kind < 4)
                begin
                    send_frame(slfr_pkg::SECOND_BYTE,
                               8'($urandom_range(slfr_pkg::BUFFER_BYTES - 2, 255)), 1'b0);
                end
                else if (kind < 9)
                begin
                    send_frame(slfr_pkg::SECOND_BYTE, 8'($urandom_range(1)), 1'b0);
                end
                else if (kind < 19)
                begin
                    send_frame(slfr_pkg::SECOND_BYTE, 8'($urandom_range(2, 24)), 1'b1);
                end
                else if (kind < 24)
                begin
                    send_frame(slfr_pkg::SECOND_BYTE,
                               8'($urandom_range(2, slfr_pkg::BUFFER_BYTES - 3)), 1'b0);
                end
                else
                begin
                    send_frame(slfr_pkg::SECOND_BYTE, 8'($urandom_range(2, 16)), 1'b0);
                end
            end
            // hold the sender until every report is out
            drain();
        end

        repeat (8) @(posedge clk);
        $display("Sent %0d bytes (%0d dropped before sync) under four throttle mixes.",
                 beats_sent, ignored_beats);
        $display("Compared %0d frame reports, %0d with a matching CRC.",
                 reports_seen, good_crc_seen);
        if (fail_count == 0)
        begin
            $display("ALL CHECKS PASSED");
        end
        else
        begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule
